FILE: design/whrm_pkg.sv
// ----------------------------------------------------------------------------
// whrm_pkg: shared constants and types of the heartbeat rate meter
// Field widths, ring geometry, rate constants and the request and response
// bundles of the shared divider.
// ----------------------------------------------------------------------------
package whrm_pkg;

	// Block configuration.
	localparam int WINDOWS       = 4;
	localparam int HISTORY       = 64;
	localparam int MEASURE_SCALE = 1;

	// Time and rate constants: the beat count is scaled by RATE_MULT and the
	// span is taken in units of SPAN_UNIT_NS nanoseconds.
	localparam int RATE_MULT    = 1000000;
	localparam int SPAN_UNIT_NS = 1000;

	// Field widths fixed by the interface.
	localparam int BEAT_W = 48;
	localparam int TIME_W = 63;
	localparam int RATE_W = 64;
	localparam int SLOT_W = 3;
	localparam int WLEN_W = 7;
	localparam int DATA_W = 32;

	// Ring and window bookkeeping widths.
	localparam int POS_W     = (HISTORY > 1) ? $clog2(HISTORY) : 1;
	localparam int FILL_W    = $clog2(HISTORY + 1);
	localparam int CMP_W     = (FILL_W > WLEN_W) ? FILL_W : WLEN_W;
	localparam int IDX_W     = $clog2(WINDOWS + 1);
	localparam int WIN_IDX_W = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
	localparam int PADDR_W   = WIN_IDX_W + 2;
	localparam int RING_W    = BEAT_W + TIME_W;

	// Multiplier: half of a beat count times the per-second scale.
	localparam int USEC_W = 20;
	localparam int HALF_W = BEAT_W / 2;
	localparam int MUL_W  = HALF_W + USEC_W;
	localparam int PROD_W = BEAT_W + USEC_W;
	localparam logic [USEC_W-1:0] USEC_K = USEC_W'(RATE_MULT);

	// Divider geometry.
	localparam int DIV_W     = 64;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam logic [DIV_W-1:0] SPAN_DIV = DIV_W'(SPAN_UNIT_NS * MEASURE_SCALE);

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] hi;
		logic [DIV_W-1:0] lo;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

endpackage

FILE: design/whrm_divider.sv
// ----------------------------------------------------------------------------
// whrm_divider: shared restoring divider of the heartbeat rate meter
// Divides a two-word dividend by one word, one quotient bit per cycle, and
// saturates to all ones when the quotient does not fit one word.
// ----------------------------------------------------------------------------
module whrm_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  whrm_pkg::div_req_t  req,
	output whrm_pkg::div_rsp_t  rsp
);

	logic                            busy_q;
	logic                            check_q;
	logic                            done_q;
	logic [whrm_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [whrm_pkg::DIV_W-1:0]      hi_q;
	logic [whrm_pkg::DIV_W-1:0]      lo_q;
	logic [whrm_pkg::DIV_W-1:0]      den_q;
	logic [whrm_pkg::DIV_W-1:0]      quot_q;

	logic [whrm_pkg::DIV_W-1:0]      hi_sh;
	logic [whrm_pkg::DIV_W-1:0]      cmp_a;
	logic                            ge;
	logic                            take;
	logic [whrm_pkg::DIV_W-1:0]      diff;

	// One comparator serves both the overflow check and the iterations.
	always_comb begin
		hi_sh = {hi_q[whrm_pkg::DIV_W-2:0], lo_q[whrm_pkg::DIV_W-1]};
		cmp_a = check_q ? hi_q : hi_sh;
		ge    = (cmp_a >= den_q);
		take  = hi_q[whrm_pkg::DIV_W-1] || ge;
		diff  = hi_sh - den_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			check_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				check_q <= 1'b1;
				cnt_q   <= whrm_pkg::DIV_CNT_W'(whrm_pkg::DIV_W);
			end else if (busy_q && check_q) begin
				check_q <= 1'b0;
				if (ge) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - whrm_pkg::DIV_CNT_W'(1);
				if (cnt_q == whrm_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			hi_q   <= req.hi;
			lo_q   <= req.lo;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q && check_q) begin
			if (ge) begin
				quot_q <= '1;
			end
		end else if (busy_q) begin
			lo_q   <= {lo_q[whrm_pkg::DIV_W-2:0], 1'b0};
			hi_q   <= take ? diff : hi_sh;
			quot_q <= {quot_q[whrm_pkg::DIV_W-2:0], take};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

FILE: design/windowed_heartbeat_rate_meter_top.sv
// ----------------------------------------------------------------------------
// windowed_heartbeat_rate_meter_top: sliding-window heartbeat rate meter
// Keeps a ring of heartbeat totals and timestamps and reports beat counts,
// spans and rates for the whole run and for up to four windows per tick.
// ----------------------------------------------------------------------------
// Usage.
// Each beat on the tick channel (tick_valid, tick_stall, total_beats,
// elapsed_ns) is one sampling tick. The block stores it in a 64-entry history
// ring and then sends, on the result channel (res_valid, res_stall, slot,
// beat_count, span_ns, rate, last), the global result in slot 0 followed by one
// result for each window whose length register is nonzero, in register order.
// last marks the final result of a tick. Window lengths are written through
// the APB port at byte address 4*i and should only change while idle.
//
// Timing. A result passes through the span/1000 division (start, overflow
// check, 64 iterations and the done cycle), the two halves of the beats*1e6
// product and their sum, the rate division and the load of the output
// register; a zero divisor or a saturated rate cuts the rate division
// short. A window result adds its scan and ring read, and the scan steps
// over each disabled window. The shared divider's 64 iterations per division
// set most of the time that a tick with all four windows enabled takes.
// tick_stall is high from the accepted tick until its last result sits in the
// output register, so the next tick is taken while that result still waits.
//
// Reset clears the window registers, the ring valid bits (unwritten entries
// read as zero) and the output valid bit. A stalled receiver holds the result
// in the output register and the sequencer waits before loading the next one.
// ----------------------------------------------------------------------------
module windowed_heartbeat_rate_meter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [whrm_pkg::PADDR_W-1:0]        paddr,
	input  logic [whrm_pkg::DATA_W-1:0]         pwdata,
	output logic [whrm_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	// Tick channel.
	input  logic                                tick_valid,
	output logic                                tick_stall,
	input  logic [whrm_pkg::BEAT_W-1:0]         total_beats,
	input  logic [whrm_pkg::TIME_W-1:0]         elapsed_ns,
	// Result channel.
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [whrm_pkg::SLOT_W-1:0]         slot,
	output logic [whrm_pkg::BEAT_W-1:0]         beat_count,
	output logic [whrm_pkg::TIME_W-1:0]         span_ns,
	output logic [whrm_pkg::RATE_W-1:0]         rate,
	output logic                                last
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_RD,
		S_DDIV,
		S_DWAIT,
		S_MLO,
		S_MHI,
		S_SUM,
		S_RDIV,
		S_RWAIT,
		S_EMIT
	} state_t;

	state_t state_q;

	// Window length registers.
	logic [whrm_pkg::WLEN_W-1:0]    win_len_q [whrm_pkg::WINDOWS];
	logic [whrm_pkg::WIN_IDX_W-1:0] cfg_idx;
	logic                           cfg_hit;
	logic                           cfg_wr;

	// Ring and its bookkeeping.
	logic [whrm_pkg::RING_W-1:0]    ring_mem [whrm_pkg::HISTORY];
	logic [whrm_pkg::HISTORY-1:0]   ring_vld_q;
	logic [whrm_pkg::RING_W-1:0]    rd_q;
	logic                           rd_vld_q;
	logic [whrm_pkg::POS_W-1:0]     write_pos_q;
	logic [whrm_pkg::FILL_W-1:0]    filled_q;
	logic [whrm_pkg::IDX_W-1:0]     scan_idx_q;

	// Working registers of the current tick and result.
	logic [whrm_pkg::BEAT_W-1:0]    beats_q;
	logic [whrm_pkg::TIME_W-1:0]    now_q;
	logic [whrm_pkg::SLOT_W-1:0]    res_slot_q;
	logic [whrm_pkg::BEAT_W-1:0]    res_beats_q;
	logic [whrm_pkg::TIME_W-1:0]    res_span_q;
	logic [whrm_pkg::DIV_W-1:0]     d_q;
	logic [whrm_pkg::MUL_W-1:0]     plo_q;
	logic [whrm_pkg::MUL_W-1:0]     phi_q;
	logic [whrm_pkg::PROD_W-1:0]    prod_q;
	logic [whrm_pkg::RATE_W-1:0]    rate_q;

	// Output register.
	logic                           res_valid_q;
	logic [whrm_pkg::SLOT_W-1:0]    slot_q;
	logic [whrm_pkg::BEAT_W-1:0]    beat_count_q;
	logic [whrm_pkg::TIME_W-1:0]    span_q;
	logic [whrm_pkg::RATE_W-1:0]    rate_out_q;
	logic                           last_q;

	// Combinational helpers.
	logic                           tick_acc;
	logic                           out_free;
	logic [whrm_pkg::WLEN_W-1:0]    wlen_sel;
	logic                           win_nz;
	logic                           more;
	logic [whrm_pkg::FILL_W-1:0]    ws;
	logic [whrm_pkg::FILL_W:0]      first_sum;
	logic [whrm_pkg::POS_W-1:0]     rd_addr;
	logic                           rd_en;
	logic [whrm_pkg::POS_W-1:0]     wp_next;
	logic [whrm_pkg::BEAT_W-1:0]    old_beats;
	logic [whrm_pkg::TIME_W-1:0]    old_time;
	logic [whrm_pkg::HALF_W-1:0]    mul_a;
	logic [whrm_pkg::MUL_W-1:0]     mul_p;
	whrm_pkg::div_req_t             div_req;
	whrm_pkg::div_rsp_t             div_rsp;

	// ------------------------------------------------------------------
	// Configuration port. Each write completes in its access cycle; a
	// write to an index beyond the window registers is dropped.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[whrm_pkg::PADDR_W-1:2];
	assign cfg_hit = (int'(cfg_idx) < whrm_pkg::WINDOWS);
	assign cfg_wr  = psel && penable && pwrite && cfg_hit;

	always_comb begin
		prdata = '0;
		if (cfg_hit) begin
			prdata = whrm_pkg::DATA_W'(win_len_q[cfg_idx]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < whrm_pkg::WINDOWS; i++) begin
				win_len_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			win_len_q[cfg_idx] <= pwdata[whrm_pkg::WLEN_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Window scan and ring address. The window length is clamped to the
	// number of filled entries and the compared entry lies that many
	// ticks behind the one just written.
	// ------------------------------------------------------------------
	assign tick_acc = tick_valid && (state_q == S_IDLE);
	assign out_free = !res_valid_q || !res_stall;
	assign wlen_sel = win_len_q[scan_idx_q[whrm_pkg::WIN_IDX_W-1:0]];
	assign win_nz   = (wlen_sel != '0);

	// Another result follows when some window at or past the scan point
	// is enabled.
	always_comb begin
		more = 1'b0;
		for (int j = 0; j < whrm_pkg::WINDOWS; j++) begin
			if ((win_len_q[j] != '0) && (j >= int'(scan_idx_q))) begin
				more = 1'b1;
			end
		end
	end

	always_comb begin
		if (whrm_pkg::CMP_W'(wlen_sel) > whrm_pkg::CMP_W'(filled_q)) begin
			ws = filled_q;
		end else begin
			ws = whrm_pkg::FILL_W'(wlen_sel);
		end
		first_sum = (whrm_pkg::FILL_W+1)'(write_pos_q)
			+ (whrm_pkg::FILL_W+1)'(whrm_pkg::HISTORY)
			- (whrm_pkg::FILL_W+1)'(ws);
		if (first_sum >= (whrm_pkg::FILL_W+1)'(whrm_pkg::HISTORY)) begin
			rd_addr = whrm_pkg::POS_W'(first_sum
				- (whrm_pkg::FILL_W+1)'(whrm_pkg::HISTORY));
		end else begin
			rd_addr = whrm_pkg::POS_W'(first_sum);
		end
	end

	assign rd_en = (state_q == S_SCAN) && win_nz;

	assign wp_next = (write_pos_q == whrm_pkg::POS_W'(whrm_pkg::HISTORY - 1))
		? '0 : write_pos_q + whrm_pkg::POS_W'(1);

	// ------------------------------------------------------------------
	// History ring. Writes happen only when a tick is taken and reads
	// only during the scan, so the two never meet in one cycle. An entry
	// that was never written reads as zero through its valid bit.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			ring_mem[write_pos_q] <= {total_beats, elapsed_ns};
		end
		if (rd_en) begin
			rd_q <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (tick_acc) begin
				ring_vld_q[write_pos_q] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= ring_vld_q[rd_addr];
			end
		end
	end

	assign old_beats = rd_vld_q ? rd_q[whrm_pkg::RING_W-1:whrm_pkg::TIME_W] : '0;
	assign old_time  = rd_vld_q ? rd_q[whrm_pkg::TIME_W-1:0] : '0;

	// ------------------------------------------------------------------
	// Shared multiplier: one half of the beat count per cycle.
	// ------------------------------------------------------------------
	assign mul_a = (state_q == S_MLO) ? res_beats_q[whrm_pkg::HALF_W-1:0]
		: res_beats_q[whrm_pkg::BEAT_W-1:whrm_pkg::HALF_W];
	assign mul_p = whrm_pkg::MUL_W'(mul_a) * whrm_pkg::MUL_W'(whrm_pkg::USEC_K);

	// ------------------------------------------------------------------
	// Shared divider. The first pass turns the span into the divisor
	// span/1000/scale; the second divides the scaled beat count by it.
	// ------------------------------------------------------------------
	always_comb begin
		div_req.start = (state_q == S_DDIV) || ((state_q == S_RDIV) && (d_q != '0));
		if (state_q == S_DDIV) begin
			div_req.hi  = '0;
			div_req.lo  = whrm_pkg::DIV_W'(res_span_q);
			div_req.den = whrm_pkg::SPAN_DIV;
		end else begin
			div_req.hi  = whrm_pkg::DIV_W'(prod_q[whrm_pkg::PROD_W-1:whrm_pkg::DIV_W]);
			div_req.lo  = prod_q[whrm_pkg::DIV_W-1:0];
			div_req.den = d_q;
		end
	end

	whrm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------------------------
	// Sequencer and output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			write_pos_q <= whrm_pkg::POS_W'(1 % whrm_pkg::HISTORY);
			filled_q    <= whrm_pkg::FILL_W'(1);
			scan_idx_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// In the emit state the load below handles the output handshake.
			if (res_valid_q && !res_stall && (state_q != S_EMIT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (tick_valid) begin
						beats_q     <= total_beats;
						now_q       <= elapsed_ns;
						res_beats_q <= total_beats;
						res_span_q  <= elapsed_ns;
						res_slot_q  <= '0;
						scan_idx_q  <= '0;
						state_q     <= S_DDIV;
					end
				end
				S_SCAN: begin
					scan_idx_q <= scan_idx_q + whrm_pkg::IDX_W'(1);
					if (win_nz) begin
						res_slot_q <= whrm_pkg::SLOT_W'(scan_idx_q + whrm_pkg::IDX_W'(1));
						state_q    <= S_RD;
					end
				end
				S_RD: begin
					// Differences wrap at the field widths when a counter
					// or clock runs backward.
					res_beats_q <= beats_q - old_beats;
					res_span_q  <= now_q - old_time;
					state_q     <= S_DDIV;
				end
				S_DDIV: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_rsp.done) begin
						d_q     <= div_rsp.quot;
						state_q <= S_MLO;
					end
				end
				S_MLO: begin
					plo_q   <= mul_p;
					state_q <= S_MHI;
				end
				S_MHI: begin
					phi_q   <= mul_p;
					state_q <= S_SUM;
				end
				S_SUM: begin
					prod_q  <= whrm_pkg::PROD_W'(plo_q)
						+ (whrm_pkg::PROD_W'(phi_q) << whrm_pkg::HALF_W);
					state_q <= S_RDIV;
				end
				S_RDIV: begin
					// A span under one microsecond unit gives rate zero.
					if (d_q == '0) begin
						rate_q  <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_RWAIT;
					end
				end
				S_RWAIT: begin
					if (div_rsp.done) begin
						rate_q  <= div_rsp.quot;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						res_valid_q  <= 1'b1;
						slot_q       <= res_slot_q;
						beat_count_q <= res_beats_q;
						span_q       <= res_span_q;
						rate_out_q   <= rate_q;
						last_q       <= !more;
						if (more) begin
							state_q <= S_SCAN;
						end else begin
							write_pos_q <= wp_next;
							if (filled_q < whrm_pkg::FILL_W'(whrm_pkg::HISTORY)) begin
								filled_q <= filled_q + whrm_pkg::FILL_W'(1);
							end
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign tick_stall = (state_q != S_IDLE);
	assign res_valid  = res_valid_q;
	assign slot       = slot_q;
	assign beat_count = beat_count_q;
	assign span_ns    = span_q;
	assign rate       = rate_out_q;
	assign last       = last_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// A taken tick keeps the tick channel stalled while its results are made.
	a_tick_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_valid && !tick_stall) |=> tick_stall)
		else $error("tick channel not stalled after a taken tick");

	// The divider is never restarted in the middle of a division.
	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// The entry of a taken tick is marked valid before any window reads it.
	a_ring_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_valid && !tick_stall) |=> ring_vld_q[write_pos_q])
		else $error("ring entry of the taken tick not marked valid");

endmodule

FILE: dv/windowed_heartbeat_rate_meter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_heartbeat_rate_meter_top_tb: self-checking bench of the rate meter
// Sends sampling ticks with random sender gaps and receiver stalls, and
// rewrites the window lengths over APB between phases. Every result beat is
// compared, field by field, against a model of the history ring, the window
// clamping and the saturating rate division that runs in the bench.
// ----------------------------------------------------------------------------
module windowed_heartbeat_rate_meter_top_tb;
	import whrm_pkg::*;

	localparam int RESET_CYCLES  = 10;
	// No beat on any channel for this long means the block has hung. The limit
	// lies well above a single result plus the longest receiver stall.
	localparam int QUIET_LIMIT   = 4000;
	// Extra cycles after the last expected result before registers change or
	// the run ends.
	localparam int SETTLE_CYCLES = 16;
	localparam int REG_STRIDE    = 4;

	localparam logic [SLOT_W-1:0] SLOT_GLOBAL = '0;
	localparam logic [BEAT_W-1:0] BEAT_MAX    = '1;
	localparam logic [TIME_W-1:0] TIME_MAX    = '1;
	localparam logic [RATE_W-1:0] RATE_MAX    = '1;

	// One result beat, in the order of the result ports.
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [BEAT_W-1:0] beats;
		logic [TIME_W-1:0] span;
		logic [RATE_W-1:0] rate;
		logic              last;
	} span_meas_t;

	// Holds a copy of the window registers and the history ring, works out the
	// result beats of every accepted tick and checks them as they come out.
	class span_rate_predictor;
		logic [WLEN_W-1:0] win_len [WINDOWS];
		logic [BEAT_W-1:0] ring_beats [HISTORY];
		logic [TIME_W-1:0] ring_ns [HISTORY];
		int                wr_pos;
		int                fill;
		span_meas_t        due_results [$];
		int                errors;

		function new();
			for (int i = 0; i < WINDOWS; i++)
				win_len[i] = '0;
			for (int i = 0; i < HISTORY; i++) begin
				ring_beats[i] = '0;
				ring_ns[i]    = '0;
			end
			wr_pos = 1 % HISTORY;
			fill   = 1;
			errors = 0;
		endfunction

		function void set_window(int idx, logic [WLEN_W-1:0] len);
			if (idx < WINDOWS)
				win_len[idx] = len;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// Beats times 1e6 over span/1000/scale, zero for a zero divisor and
		// saturated where the quotient does not fit the rate field.
		function logic [RATE_W-1:0] rate_for(logic [BEAT_W-1:0] beats,
				logic [TIME_W-1:0] span);
			logic [127:0] divisor;
			logic [127:0] quotient;
			divisor = 128'(span) / 128'(SPAN_UNIT_NS) / 128'(MEASURE_SCALE);
			if (divisor == '0)
				return '0;
			quotient = (128'(beats) * 128'(RATE_MULT)) / divisor;
			if (quotient[127:RATE_W] != '0)
				return RATE_MAX;
			return quotient[RATE_W-1:0];
		endfunction

		function void add_meas(logic [SLOT_W-1:0] slot, logic [BEAT_W-1:0] beats,
				logic [TIME_W-1:0] span, logic last);
			due_results.push_back({slot, beats, span, rate_for(beats, span), last});
		endfunction

		function void take_tick(logic [BEAT_W-1:0] beats, logic [TIME_W-1:0] ns);
			int cur;
			int first;
			int span_len;
			int last_win;
			cur = wr_pos;
			ring_beats[cur] = beats;
			ring_ns[cur]    = ns;
			last_win = -1;
			for (int i = 0; i < WINDOWS; i++)
				if (win_len[i] != '0)
					last_win = i;
			add_meas(SLOT_GLOBAL, beats, ns, last_win < 0);
			for (int i = 0; i < WINDOWS; i++) begin
				span_len = int'(win_len[i]);
				if (span_len != 0) begin
					// Windows longer than the filled part of the ring are clamped.
					if (span_len > fill)
						span_len = fill;
					first = (cur + HISTORY - span_len) % HISTORY;
					add_meas(SLOT_W'(i + 1), beats - ring_beats[first],
						ns - ring_ns[first], i == last_win);
				end
			end
			if (fill < HISTORY)
				fill++;
			wr_pos = (cur + 1) % HISTORY;
		endfunction

		function void compare(string field, logic [RATE_W-1:0] want,
				logic [RATE_W-1:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(span_meas_t got);
			span_meas_t want;
			if (due_results.size() == 0) begin
				$display("%0t: result in slot %0d with nothing expected", $time, got.slot);
				errors++;
				return;
			end
			want = due_results.pop_front();
			compare("slot", RATE_W'(want.slot), RATE_W'(got.slot));
			compare("beat_count", RATE_W'(want.beats), RATE_W'(got.beats));
			compare("span_ns", RATE_W'(want.span), RATE_W'(got.span));
			compare("rate", want.rate, got.rate);
			compare("last", RATE_W'(want.last), RATE_W'(got.last));
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                tick_valid;
	logic                tick_stall;
	logic [BEAT_W-1:0]   total_beats;
	logic [TIME_W-1:0]   elapsed_ns;
	logic                res_valid;
	logic                res_stall = 1'b0;
	logic [SLOT_W-1:0]   slot;
	logic [BEAT_W-1:0]   beat_count;
	logic [TIME_W-1:0]   span_ns;
	logic [RATE_W-1:0]   rate;
	logic                last;

	span_rate_predictor  meter;
	int                  stall_hold = 0;
	int                  quiet_cycles = 0;
	// Running heartbeat total and clock of the well-formed tick stream.
	logic [BEAT_W-1:0]   run_beats;
	logic [TIME_W-1:0]   run_ns;

	windowed_heartbeat_rate_meter_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.total_beats(total_beats),
		.elapsed_ns (elapsed_ns),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.slot       (slot),
		.beat_count (beat_count),
		.span_ns    (span_ns),
		.rate       (rate),
		.last       (last)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver stall pattern. Each stretch picks a level and a length: open
	// stretches, short stalls, and now and then a long stall. Stretches are
	// drawn independently of the block, so stalls land on every phase of its work.
	always @(posedge clk) begin
		int pick;
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				res_stall  <= 1'b0;
				stall_hold <= $urandom_range(0, 40);
			end else if (pick < 90) begin
				res_stall  <= 1'b1;
				stall_hold <= $urandom_range(0, 3);
			end else begin
				res_stall  <= 1'b1;
				stall_hold <= $urandom_range(20, 120);
			end
		end
	end

	// Result monitor. Values are read right after the edge, before the block's
	// registers update, so they are the ones that the edge accepted.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			meter.check_result({slot, beat_count, span_ns, rate, last});
	end

	// Watchdog: any beat on either channel or an APB access clears the count.
	always @(posedge clk) begin
		if (!arst_n || (tick_valid && !tick_stall) || (res_valid && !res_stall) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Sender gap before a tick: mostly none, sometimes a short one, and now and
	// then a long pause. Valid only drops when a gap is actually taken, so it
	// never falls and rises within the same step.
	task automatic sender_gap();
		int pick;
		int gap;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			gap = 0;
		else if (pick < 93)
			gap = $urandom_range(1, 6);
		else
			gap = $urandom_range(40, 200);
		if (gap > 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Offers one tick and holds it until the block takes it, then lets the
	// predictor record it.
	task automatic send_tick(logic [BEAT_W-1:0] beats, logic [TIME_W-1:0] ns);
		sender_gap();
		tick_valid  <= 1'b1;
		total_beats <= beats;
		elapsed_ns  <= ns;
		do
			@(posedge clk);
		while (tick_stall);
		meter.take_tick(beats, ns);
	endtask

	// Stops the sender and waits until every expected result has arrived, plus
	// a short settle time.
	task automatic wait_drained();
		tick_valid <= 1'b0;
		while (meter.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready. The bus then idles
	// so that a back-to-back write starts in a later step.
	task automatic write_window(int idx, logic [WLEN_W-1:0] len);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(REG_STRIDE * idx);
		pwdata  <= DATA_W'(len);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		meter.set_window(idx, len);
		@(posedge clk);
	endtask

	// Registers only change while the block is idle.
	task automatic set_windows(logic [WLEN_W-1:0] len0, logic [WLEN_W-1:0] len1,
			logic [WLEN_W-1:0] len2, logic [WLEN_W-1:0] len3);
		wait_drained();
		write_window(0, len0);
		write_window(1, len1);
		write_window(2, len2);
		write_window(3, len3);
	endtask

	// Random ticks. Most follow a monotonic counter and clock with random
	// steps; the rest are full-width noise, which also reseeds the stream so
	// that the high bits of both fields toggle and spans go backward.
	task automatic run_ticks(int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				run_beats = BEAT_W'({$urandom, $urandom});
				run_ns    = TIME_W'({$urandom, $urandom});
			end else begin
				run_beats = run_beats + BEAT_W'($urandom_range(0, 5000));
				pick = $urandom_range(0, 99);
				if (pick < 70)
					run_ns = run_ns + TIME_W'($urandom_range(1000000, 100000000));
				else if (pick < 90)
					run_ns = run_ns + TIME_W'($urandom_range(0, 5000));
				else
					run_ns = run_ns + (TIME_W'($urandom) << 20);
			end
			send_tick(run_beats, run_ns);
		end
	endtask

	initial begin
		meter = new();
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		tick_valid  <= 1'b0;
		total_beats <= '0;
		elapsed_ns  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: every window is off, so only the global result comes.
		// Covers a zero divisor, a span just under and at one microsecond, and
		// a saturated rate.
		send_tick('0, '0);
		send_tick(BEAT_W'(1), TIME_W'(999));
		send_tick(BEAT_W'(1), TIME_W'(1000));
		send_tick(BEAT_MAX, TIME_W'(1000));

		// A disabled window between enabled ones, and a window far longer than
		// the ring, which is clamped to the entries filled so far.
		set_windows(WLEN_W'(1), WLEN_W'(0), WLEN_W'(3), WLEN_W'(127));
		send_tick(BEAT_MAX, TIME_MAX);
		// Counter and clock going backward wrap the differences.
		send_tick('0, '0);
		send_tick(BEAT_W'(5), TIME_MAX);
		send_tick(BEAT_W'(10), TIME_W'(500));
		send_tick(BEAT_W'(1000), TIME_W'(2000));
		send_tick(48'h8000_0000_0000, 63'h4000_0000_0000_0000);
		send_tick(BEAT_W'(123456789), TIME_W'(1000000000));
		send_tick(BEAT_MAX, TIME_W'(1500));
		send_tick('0, TIME_W'(1000));
		send_tick(BEAT_W'(1), TIME_W'(1));
		send_tick(48'h5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
		send_tick(48'hAAAA_AAAA_AAAA, 63'h5555_5555_5555_5555);

		run_beats = BEAT_W'($urandom_range(0, 100000));
		run_ns    = TIME_W'($urandom_range(0, 100000000));

		set_windows('0, '0, '0, '0);
		run_ticks(30);
		// Full-ring windows: once the ring has wrapped, each compares the tick
		// with itself.
		set_windows(WLEN_W'(64), WLEN_W'(64), WLEN_W'(64), WLEN_W'(64));
		run_ticks(40);
		set_windows(WLEN_W'(1), WLEN_W'(127), WLEN_W'(0), WLEN_W'(32));
		run_ticks(40);
		set_windows(WLEN_W'($urandom_range(0, 127)), WLEN_W'($urandom_range(0, 127)),
			WLEN_W'($urandom_range(0, 127)), WLEN_W'($urandom_range(0, 127)));
		run_ticks(35);
		set_windows(WLEN_W'(127), WLEN_W'(1), WLEN_W'(64), WLEN_W'(2));
		run_ticks(35);

		wait_drained();
		if (meter.errors == 0 && meter.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
design/whrm_pkg.sv
design/whrm_divider.sv
design/windowed_heartbeat_rate_meter_top.sv
dv/windowed_heartbeat_rate_meter_top_tb.sv
